>>> rtl/servo_output_bank_controller_top_macros.svh
// Assertion macros shared by the servo output bank checker.
`ifndef SERVO_OUTPUT_BANK_CONTROLLER_TOP_MACROS_SVH
`define SERVO_OUTPUT_BANK_CONTROLLER_TOP_MACROS_SVH

// Implication in the same cycle, sampled on clk and quiet during reset.
`define SOBC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication checked in the next cycle.
`define SOBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sobc_pkg.sv
// Types, constants and helpers of the servo output bank controller.
package sobc_pkg;

	localparam int CHANNEL_COUNT_DEF    = 16;
	localparam int DIGITAL_CHANNELS_DEF = 8;

	localparam int              NUM_OUT      = 16;
	localparam logic [15:0]     BANK_MASK    = 16'h00FF;
	localparam logic [19:0]     PERIOD_NUM   = 20'd1000000;
	localparam logic [15:0]     DEFAULT_RATE = 16'd50;
	localparam logic [15:0]     RESET_PULSE  = 16'd1000;
	localparam logic [15:0]     PULSE_MIN    = 16'd1000;
	localparam logic [15:0]     PULSE_MAX    = 16'd2000;
	localparam logic [15:0]     CODE_CAP     = 16'd1999;
	localparam logic [15:0]     CODE_OFFSET  = 16'd48;
	localparam logic [4:0]      DIV_STEPS    = 5'd20;

	typedef enum logic [3:0] {
		OP_WRITE    = 4'd0,
		OP_ENABLE   = 4'd1,
		OP_DISABLE  = 4'd2,
		OP_RATE     = 4'd3,
		OP_CORK     = 4'd4,
		OP_PUSH     = 4'd5,
		OP_SAFE_ON  = 4'd6,
		OP_SAFE_OFF = 4'd7,
		OP_MODE     = 4'd8
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DIV,
		ST_APPLY,
		ST_TICK
	} st_t;

	typedef struct packed {
		logic [3:0]  opcode;
		logic [4:0]  channel;
		logic [15:0] pulse_width_us;
		logic [15:0] channel_mask;
		logic [15:0] rate_hz;
		logic        digital_mode;
		logic        armed;
		logic        tick;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  out_channel;
		logic [19:0] frame_us;
		logic [15:0] pulse_or_code;
		logic        last;
	} res_item_t;

	typedef struct packed {
		logic       accept;
		logic       div_start;
		logic       emit_apply;
		logic       emit_tick;
		logic [3:0] idx;
	} ctl_cmd_t;

	typedef struct packed {
		logic hit;
		logic tick_pend;
		logic div_done;
		logic out_free;
	} dp_stat_t;

	// Bits set for every channel below n, within the sixteen outputs.
	function automatic logic [15:0] chan_valid_mask(input int n);
		logic [15:0] m;
		m = '0;
		for (int i = 0; i < NUM_OUT; i++) begin
			if (i < n)
				m[i] = 1'b1;
		end
		return m;
	endfunction

endpackage

>>> rtl/sobc_if.sv
// Valid/ready channel interfaces for commands and results.
interface sobc_cmd_if;
	logic        valid;
	logic        ready;
	logic [3:0]  opcode;
	logic [4:0]  channel;
	logic [15:0] pulse_width_us;
	logic [15:0] channel_mask;
	logic [15:0] rate_hz;
	logic        digital_mode;
	logic        armed;
	logic        tick;

	modport source (output valid, opcode, channel, pulse_width_us, channel_mask, rate_hz,
		digital_mode, armed, tick, input ready);
	modport sink (input valid, opcode, channel, pulse_width_us, channel_mask, rate_hz,
		digital_mode, armed, tick, output ready);
endinterface

interface sobc_res_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [3:0]  out_channel;
	logic [19:0] frame_us;
	logic [15:0] pulse_or_code;
	logic        last;

	modport source (output valid, kind, out_channel, frame_us, pulse_or_code, last,
		input ready);
	modport sink (input valid, kind, out_channel, frame_us, pulse_or_code, last,
		output ready);
endinterface

>>> rtl/servo_output_bank_controller_top.sv
// Top level of the servo output bank controller.
// The bank takes one command transfer at a time and returns its results as a stream of
// transfers, the final one flagged by last. Once a command is accepted, the sequencer
// scans each of the sixteen outputs in turn, and for every output it applies it loads
// the shared restoring divider, runs its twenty quotient steps, sees the divider finish
// and emits the transfer; after the scan it emits any throttle codes. Results wait in a
// single output register, so a slow consumer only stretches the emission steps. The
// present mask is written through cfg_we and cfg_wdata and takes effect for the next
// command.
module servo_output_bank_controller_top #(
	parameter int CHANNEL_COUNT    = sobc_pkg::CHANNEL_COUNT_DEF,
	parameter int DIGITAL_CHANNELS = sobc_pkg::DIGITAL_CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	sobc_cmd_if.sink    cmd,
	sobc_res_if.source  res
);

	sobc_pkg::in_item_t  item;
	sobc_pkg::ctl_cmd_t  ctl;
	sobc_pkg::dp_stat_t  stat;
	sobc_pkg::res_item_t res_item;
	logic                out_valid;

	// Command payload gathered into one word for the datapath.
	assign item.opcode         = cmd.opcode;
	assign item.channel        = cmd.channel;
	assign item.pulse_width_us = cmd.pulse_width_us;
	assign item.channel_mask   = cmd.channel_mask;
	assign item.rate_hz        = cmd.rate_hz;
	assign item.digital_mode   = cmd.digital_mode;
	assign item.armed          = cmd.armed;
	assign item.tick           = cmd.tick;

	sobc_ctrl #(
		.DIGITAL_CHANNELS (DIGITAL_CHANNELS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd.valid),
		.in_ready (cmd.ready),
		.stat     (stat),
		.cmd      (ctl)
	);

	sobc_dp #(
		.CHANNEL_COUNT    (CHANNEL_COUNT),
		.DIGITAL_CHANNELS (DIGITAL_CHANNELS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.item      (item),
		.cmd       (ctl),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (res.ready),
		.res       (res_item)
	);

	// Result register straight onto the output channel.
	assign res.valid         = out_valid;
	assign res.kind          = res_item.kind;
	assign res.out_channel   = res_item.out_channel;
	assign res.frame_us      = res_item.frame_us;
	assign res.pulse_or_code = res_item.pulse_or_code;
	assign res.last          = res_item.last;

endmodule

>>> rtl/sobc_ctrl.sv
// Sequencer that walks the channels of one command and then its throttle codes.
module sobc_ctrl #(
	parameter int DIGITAL_CHANNELS = sobc_pkg::DIGITAL_CHANNELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sobc_pkg::dp_stat_t  stat,
	output sobc_pkg::ctl_cmd_t  cmd
);

	localparam int NTICK = (DIGITAL_CHANNELS < 8) ? DIGITAL_CHANNELS : 8;
	localparam logic [3:0] TICK_LAST = 4'(NTICK - 1);
	localparam logic [3:0] SCAN_LAST = 4'(sobc_pkg::NUM_OUT - 1);

	sobc_pkg::st_t state_q, state_n;
	logic [3:0]    idx_q, idx_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sobc_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_n;
			idx_q   <= idx_n;
		end
	end

	always_comb begin
		state_n  = state_q;
		idx_n    = idx_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.idx  = idx_q;
		unique case (state_q)
			sobc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					idx_n      = '0;
					state_n    = sobc_pkg::ST_SCAN;
				end
			end
			sobc_pkg::ST_SCAN: begin
				if (stat.hit) begin
					cmd.div_start = 1'b1;
					state_n       = sobc_pkg::ST_DIV;
				end else if (idx_q == SCAN_LAST) begin
					idx_n   = '0;
					state_n = stat.tick_pend ? sobc_pkg::ST_TICK : sobc_pkg::ST_IDLE;
				end else begin
					idx_n = idx_q + 4'd1;
				end
			end
			sobc_pkg::ST_DIV: begin
				if (stat.div_done)
					state_n = sobc_pkg::ST_APPLY;
			end
			sobc_pkg::ST_APPLY: begin
				// The hit bit is cleared on emission, so the scan moves on by itself.
				if (stat.out_free) begin
					cmd.emit_apply = 1'b1;
					state_n        = sobc_pkg::ST_SCAN;
				end
			end
			sobc_pkg::ST_TICK: begin
				if (stat.out_free) begin
					cmd.emit_tick = 1'b1;
					if (idx_q == TICK_LAST)
						state_n = sobc_pkg::ST_IDLE;
					else
						idx_n = idx_q + 4'd1;
				end
			end
			default: state_n = sobc_pkg::ST_IDLE;
		endcase
	end

endmodule

>>> rtl/sobc_dp.sv
// Channel state, period divider and output register of the servo output bank.
module sobc_dp #(
	parameter int CHANNEL_COUNT    = sobc_pkg::CHANNEL_COUNT_DEF,
	parameter int DIGITAL_CHANNELS = sobc_pkg::DIGITAL_CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [15:0]          cfg_wdata,
	input  sobc_pkg::in_item_t   item,
	input  sobc_pkg::ctl_cmd_t   cmd,
	output sobc_pkg::dp_stat_t   stat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output sobc_pkg::res_item_t  res
);

	localparam logic [15:0] VALID = sobc_pkg::chan_valid_mask(CHANNEL_COUNT);
	localparam int NTICK = (DIGITAL_CHANNELS < 8) ? DIGITAL_CHANNELS : 8;
	localparam logic [3:0] TICK_LAST = 4'(NTICK - 1);
	localparam logic [5:0] CH_LIMIT = 6'(CHANNEL_COUNT);

	logic [15:0] pulse_q [sobc_pkg::NUM_OUT];
	logic [15:0] rate_q  [sobc_pkg::NUM_OUT];
	logic [15:0] en_q, dirty_q, present_q, eff_q;
	logic        held_q, safe_q, bank_q, armed_q, tick_q;

	logic [15:0] en_n, dirty_n, apply_set, rate_m, oh;
	logic        held_n, safe_n, bank_n, tick_n, pulse_we, ch_ok;
	sobc_pkg::op_t op;

	// Divider state: remainder, quotient shifting in over the dividend, step count.
	logic [16:0] rem_q;
	logic [19:0] quo_q;
	logic [15:0] dvs_q;
	logic [4:0]  cnt_q;
	logic [16:0] trial;

	logic        out_valid_q;
	sobc_pkg::res_item_t res_q;

	logic [15:0] sel_pulse, sel_rate, app_pulse, pc, code;
	logic [15:0] eff_rest;
	logic        code_ok;

	assign op    = sobc_pkg::op_t'(item.opcode);
	assign ch_ok = !item.channel[4] && ({1'b0, item.channel} < CH_LIMIT);
	assign oh    = ch_ok ? (16'd1 << item.channel[3:0]) : '0;

	always_comb begin
		en_n      = en_q;
		dirty_n   = dirty_q;
		held_n    = held_q;
		safe_n    = safe_q;
		bank_n    = bank_q;
		apply_set = '0;
		tick_n    = 1'b0;
		pulse_we  = 1'b0;
		rate_m    = '0;
		if (item.tick) begin
			tick_n = bank_q;
		end else begin
			unique case (op) inside
				sobc_pkg::OP_WRITE, sobc_pkg::OP_DISABLE: begin
					if (op == sobc_pkg::OP_WRITE)
						pulse_we = ch_ok;
					else
						en_n = en_q & ~oh;
					if (held_q)
						dirty_n = dirty_q | oh;
					else begin
						apply_set = oh;
						dirty_n   = dirty_q & ~oh;
					end
				end
				sobc_pkg::OP_ENABLE: begin
					en_n    = en_q | oh;
					dirty_n = dirty_q | oh;
				end
				sobc_pkg::OP_RATE: begin
					if (item.rate_hz != '0) begin
						rate_m = item.channel_mask & VALID;
						if (held_q)
							dirty_n = dirty_q | rate_m;
						else begin
							apply_set = rate_m;
							dirty_n   = dirty_q & ~rate_m;
						end
					end
				end
				sobc_pkg::OP_CORK: held_n = 1'b1;
				sobc_pkg::OP_PUSH: begin
					apply_set = dirty_q;
					dirty_n   = '0;
					held_n    = 1'b0;
				end
				sobc_pkg::OP_SAFE_ON: begin
					safe_n    = 1'b1;
					apply_set = VALID;
					dirty_n   = '0;
					tick_n    = bank_q;
				end
				sobc_pkg::OP_SAFE_OFF: safe_n = 1'b0;
				sobc_pkg::OP_MODE: begin
					if (item.channel_mask[7:0] != '0) begin
						if (item.digital_mode)
							bank_n = 1'b1;
						else begin
							if (bank_q)
								dirty_n = dirty_q | (sobc_pkg::BANK_MASK & VALID);
							bank_n = 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sobc_pkg::NUM_OUT; i++) begin
				pulse_q[i] <= sobc_pkg::RESET_PULSE;
				rate_q[i]  <= sobc_pkg::DEFAULT_RATE;
			end
			en_q      <= '0;
			dirty_q   <= '0;
			held_q    <= 1'b0;
			safe_q    <= 1'b1;
			bank_q    <= 1'b0;
			present_q <= 16'hFFFF;
			eff_q     <= '0;
			tick_q    <= 1'b0;
			armed_q   <= 1'b0;
		end else begin
			if (cfg_we)
				present_q <= cfg_wdata;
			if (cmd.accept) begin
				if (pulse_we)
					pulse_q[item.channel[3:0]] <= item.pulse_width_us;
				for (int i = 0; i < sobc_pkg::NUM_OUT; i++) begin
					if (rate_m[i])
						rate_q[i] <= item.rate_hz;
				end
				en_q    <= en_n;
				dirty_q <= dirty_n;
				held_q  <= held_n;
				safe_q  <= safe_n;
				bank_q  <= bank_n;
				eff_q   <= apply_set & present_q & ~(bank_q ? sobc_pkg::BANK_MASK : 16'h0000);
				tick_q  <= tick_n;
				armed_q <= item.armed;
			end else if (cmd.emit_apply) begin
				eff_q[cmd.idx] <= 1'b0;
			end
		end
	end

	assign sel_pulse = pulse_q[cmd.idx];
	assign sel_rate  = rate_q[cmd.idx];

	// Restoring division of the fixed numerator, one quotient bit a cycle.
	assign trial = {rem_q[15:0], quo_q[19]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= sobc_pkg::DIV_STEPS;
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= sobc_pkg::PERIOD_NUM;
			dvs_q <= (sel_rate == '0) ? sobc_pkg::DEFAULT_RATE : sel_rate;
		end else if (cnt_q != '0) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= trial - {1'b0, dvs_q};
				quo_q <= {quo_q[18:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[18:0], 1'b0};
			end
		end
	end

	always_comb begin
		app_pulse = (en_q[cmd.idx] && !safe_q) ? sel_pulse : '0;
		if ({4'd0, app_pulse} > quo_q)
			app_pulse = quo_q[15:0];
	end

	always_comb begin
		code_ok = armed_q && !safe_q && en_q[cmd.idx] && (sel_pulse != '0);
		pc      = sel_pulse;
		if (pc < sobc_pkg::PULSE_MIN)
			pc = sobc_pkg::PULSE_MIN;
		if (pc > sobc_pkg::PULSE_MAX)
			pc = sobc_pkg::PULSE_MAX;
		code = {pc[14:0] - sobc_pkg::PULSE_MIN[14:0], 1'b0};
		if (code > sobc_pkg::CODE_CAP)
			code = sobc_pkg::CODE_CAP;
		if (code != '0)
			code = code + sobc_pkg::CODE_OFFSET;
		if (!code_ok)
			code = '0;
	end

	assign eff_rest = eff_q & ~(16'd1 << cmd.idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.emit_apply || cmd.emit_tick)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_apply) begin
			res_q.kind          <= 1'b0;
			res_q.out_channel   <= cmd.idx;
			res_q.frame_us      <= quo_q;
			res_q.pulse_or_code <= app_pulse;
			res_q.last          <= (eff_rest == '0) && !tick_q;
		end else if (cmd.emit_tick) begin
			res_q.kind          <= 1'b1;
			res_q.out_channel   <= cmd.idx;
			res_q.frame_us      <= '0;
			res_q.pulse_or_code <= code;
			res_q.last          <= (cmd.idx == TICK_LAST);
		end
	end

	assign out_valid      = out_valid_q;
	assign res            = res_q;
	assign stat.hit       = eff_q[cmd.idx];
	assign stat.tick_pend = tick_q;
	assign stat.div_done  = (cnt_q == '0);
	assign stat.out_free  = !out_valid_q || out_ready;

endmodule

>>> rtl/sobc_chk.sv
// Port-level checker for the servo output bank controller, with its bind.
`include "servo_output_bank_controller_top_macros.svh"

module sobc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        kind,
	input logic [19:0] frame_us,
	input logic [15:0] pulse_or_code,
	input logic        last
);

	`SOBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(pulse_or_code) && $stable(frame_us) && $stable(last), "result changed while stalled")
	`SOBC_ASSERT_NOW(a_code_period, out_valid && kind, frame_us == 20'd0, "throttle code with a period")
	`SOBC_ASSERT_NOW(a_pulse_clamp, out_valid && !kind, {4'd0, pulse_or_code} <= frame_us, "pulse above period")
	`SOBC_ASSERT_NOW(a_code_range, out_valid && kind, pulse_or_code == 16'd0 || (pulse_or_code >= 16'd50 && pulse_or_code <= 16'd2047), "throttle code out of range")
	`SOBC_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second command taken while busy")

endmodule

bind servo_output_bank_controller_top sobc_chk u_sobc_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (cmd.valid),
	.in_ready      (cmd.ready),
	.out_valid     (res.valid),
	.out_ready     (res.ready),
	.kind          (res.kind),
	.frame_us      (res.frame_us),
	.pulse_or_code (res.pulse_or_code),
	.last          (res.last)
);

>>> tb/sv/servo_output_bank_controller_top_tb.sv
// Self-checking testbench for the servo output bank controller top level.
`timescale 1ns / 100ps

module servo_output_bank_controller_top_tb;

	localparam int N_CH            = 16;
	localparam int N_DIG           = 8;
	localparam int IDLE_LIMIT      = 20000;
	localparam int DRAIN_WAIT      = 600;
	localparam int HOLD_OFF_CYCLES = 1500;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [15:0] cfg_wdata;

	sobc_cmd_if cmd ();
	sobc_res_if res ();

	servo_output_bank_controller_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd(cmd.sink),
		.res(res.source)
	);

	// Predicted bank state, kept alongside the design.
	logic [15:0] pulse_mem [N_CH];
	logic [15:0] rate_mem [N_CH];
	logic [15:0] en_bits;
	logic [15:0] dirty;
	logic        corked;
	logic        safe;
	logic        dig_bank;
	logic [15:0] present;

	sobc_pkg::res_item_t pending_results [$];

	int   send_idle_pct;
	int   recv_stall_pct;
	logic hold_off_req;
	int   hold_cnt = 0;
	logic hold_served = 1'b0;
	int   mismatches = 0;
	int   results_seen = 0;
	int   items_sent;
	int   idle_count = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic sobc_pkg::res_item_t make_result(logic k, logic [3:0] ch,
		logic [19:0] per, logic [15:0] val);
		sobc_pkg::res_item_t r;
		r.kind = k;
		r.out_channel = ch;
		r.frame_us = per;
		r.pulse_or_code = val;
		r.last = 1'b0;
		return r;
	endfunction

	// Works out the period and pulse of one output and queues it, unless it is absent
	// or taken over by the digital bank.
	task automatic predict_apply(input int ch, inout sobc_pkg::res_item_t outs [$]);
		logic [31:0] r;
		logic [31:0] per;
		logic [31:0] p;
		if (present[ch] == 1'b0)
			return;
		if (dig_bank && ch < 8)
			return;
		r = (rate_mem[ch] == 16'd0) ? 32'd50 : {16'd0, rate_mem[ch]};
		per = 32'd1000000 / r;
		p = (!en_bits[ch] || safe) ? 32'd0 : {16'd0, pulse_mem[ch]};
		if (p > per)
			p = per;
		outs.push_back(make_result(1'b0, ch[3:0], per[19:0], p[15:0]));
	endtask

	task automatic predict_tick(input logic arm, inout sobc_pkg::res_item_t outs [$]);
		logic [31:0] p;
		logic [31:0] code;
		if (!dig_bank)
			return;
		for (int i = 0; i < N_DIG; i++) begin
			code = 0;
			if (arm && !safe && en_bits[i] && pulse_mem[i] != 16'd0) begin
				p = {16'd0, pulse_mem[i]};
				if (p < 1000)
					p = 1000;
				if (p > 2000)
					p = 2000;
				code = 2 * (p - 1000);
				if (code > 1999)
					code = 1999;
				if (code != 0)
					code = code + 48;
			end
			outs.push_back(make_result(1'b1, i[3:0], 20'd0, code[15:0]));
		end
	endtask

	// Updates the predicted state for one command and appends its expected results.
	task automatic predict_bank(input sobc_pkg::in_item_t it);
		sobc_pkg::res_item_t outs [$];
		logic ch_ok;
		int c;
		c = it.channel;
		ch_ok = it.channel < N_CH;
		if (it.tick) begin
			predict_tick(it.armed, outs);
		end else begin
			case (it.opcode)
				sobc_pkg::OP_WRITE: begin
					if (ch_ok) begin
						pulse_mem[c] = it.pulse_width_us;
						dirty[c] = 1'b1;
						if (!corked) begin
							predict_apply(c, outs);
							dirty[c] = 1'b0;
						end
					end
				end
				sobc_pkg::OP_ENABLE: begin
					if (ch_ok) begin
						en_bits[c] = 1'b1;
						dirty[c] = 1'b1;
					end
				end
				sobc_pkg::OP_DISABLE: begin
					if (ch_ok) begin
						en_bits[c] = 1'b0;
						dirty[c] = 1'b1;
						if (!corked) begin
							predict_apply(c, outs);
							dirty[c] = 1'b0;
						end
					end
				end
				sobc_pkg::OP_RATE: begin
					if (it.rate_hz != 16'd0) begin
						for (int i = 0; i < N_CH; i++) begin
							if (it.channel_mask[i]) begin
								rate_mem[i] = it.rate_hz;
								dirty[i] = 1'b1;
								if (!corked) begin
									predict_apply(i, outs);
									dirty[i] = 1'b0;
								end
							end
						end
					end
				end
				sobc_pkg::OP_CORK: corked = 1'b1;
				sobc_pkg::OP_PUSH: begin
					for (int i = 0; i < N_CH; i++) begin
						if (dirty[i]) begin
							predict_apply(i, outs);
							dirty[i] = 1'b0;
						end
					end
					corked = 1'b0;
				end
				sobc_pkg::OP_SAFE_ON: begin
					safe = 1'b1;
					for (int i = 0; i < N_CH; i++)
						predict_apply(i, outs);
					dirty = '0;
					predict_tick(it.armed, outs);
				end
				sobc_pkg::OP_SAFE_OFF: safe = 1'b0;
				sobc_pkg::OP_MODE: begin
					if ((it.channel_mask & sobc_pkg::BANK_MASK) != 16'd0) begin
						if (it.digital_mode) begin
							dig_bank = 1'b1;
						end else begin
							if (dig_bank)
								dirty[7:0] = 8'hFF;
							dig_bank = 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
		if (outs.size() > 0)
			outs[outs.size() - 1].last = 1'b1;
		foreach (outs[i])
			pending_results.push_back(outs[i]);
	endtask

	// Offers one command at a falling edge, after random idling when send_idle_pct is set,
	// and holds it until the transfer happens, then predicts it. Returns at the accepting rising edge.
	task automatic send_cmd(input sobc_pkg::in_item_t it);
		@(negedge clk);
		while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(negedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.opcode <= it.opcode;
		cmd.channel <= it.channel;
		cmd.pulse_width_us <= it.pulse_width_us;
		cmd.channel_mask <= it.channel_mask;
		cmd.rate_hz <= it.rate_hz;
		cmd.digital_mode <= it.digital_mode;
		cmd.armed <= it.armed;
		cmd.tick <= it.tick;
		do
			@(posedge clk);
		while (!cmd.ready);
		predict_bank(it);
		items_sent++;
	endtask

	function automatic sobc_pkg::in_item_t mk_cmd(sobc_pkg::op_t op, int ch, int pw,
		int mask, int rate, bit dig, bit arm, bit tk);
		sobc_pkg::in_item_t it;
		it.opcode = op;
		it.channel = ch[4:0];
		it.pulse_width_us = pw[15:0];
		it.channel_mask = mask[15:0];
		it.rate_hz = rate[15:0];
		it.digital_mode = dig;
		it.armed = arm;
		it.tick = tk;
		return it;
	endfunction

	function automatic sobc_pkg::in_item_t rand_cmd();
		sobc_pkg::in_item_t it;
		it = sobc_pkg::in_item_t'(60'({$urandom, $urandom}));
		it.tick = ($urandom_range(9, 0) == 0);
		it.opcode = ($urandom_range(19, 0) == 0) ? 4'($urandom_range(15, 9)) :
			4'($urandom_range(8, 0));
		it.channel = ($urandom_range(7, 0) == 0) ? 5'($urandom_range(31, 16)) :
			5'($urandom_range(15, 0));
		case ($urandom_range(3, 0))
			0: it.pulse_width_us = 16'($urandom);
			1: it.pulse_width_us = 16'($urandom_range(2100, 900));
			2: it.pulse_width_us = $urandom_range(1, 0) ? 16'hFFFF : 16'd0;
			default: it.pulse_width_us = 16'($urandom_range(2000, 1000));
		endcase
		if ($urandom_range(3, 0) != 0)
			it.channel_mask = ($urandom_range(7, 0) == 0) ? 16'hFFFF :
				16'd1 << $urandom_range(15, 0);
		if ($urandom_range(3, 0) == 0)
			it.rate_hz = 16'($urandom_range(400, 0));
		// Safety on is the slowest command; keep it from dominating the run.
		if (it.opcode == sobc_pkg::OP_SAFE_ON && $urandom_range(2, 0) != 0)
			it.opcode = sobc_pkg::OP_PUSH;
		return it;
	endfunction

	// Withdraws the command, waits until every expected result has arrived, then lets
	// the sequencer settle.
	task automatic wait_drained();
		@(negedge clk);
		cmd.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic write_present(input logic [15:0] val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		present = val;
	endtask

	task automatic test_directed();
		send_cmd(mk_cmd(sobc_pkg::OP_WRITE, 0, 1500, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_SAFE_OFF, 0, 0, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_ENABLE, 3, 0, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_WRITE, 3, 65535, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_WRITE, 15, 0, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_WRITE, 16, 1200, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_ENABLE, 31, 0, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_RATE, 0, 0, 16'h8009, 65535, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_RATE, 0, 0, 16'hFFFF, 0, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_RATE, 0, 0, 16'h0002, 1, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_CORK, 0, 0, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_WRITE, 1, 1800, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_ENABLE, 1, 0, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_DISABLE, 3, 0, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_PUSH, 0, 0, 0, 0, 0, 0, 0));
		// The tick flag overrides the opcode, so any code will do.
		send_cmd(mk_cmd(sobc_pkg::OP_ENABLE, 0, 0, 0, 0, 0, 1, 1));
		send_cmd(mk_cmd(sobc_pkg::OP_MODE, 0, 0, 16'hFF00, 0, 1, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_MODE, 0, 0, 16'h0001, 0, 1, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_WRITE, 2, 900, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_ENABLE, 2, 0, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_WRITE, 1, 2500, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_WRITE, 0, 0, 0, 0, 0, 1, 1));
		send_cmd(mk_cmd(sobc_pkg::OP_SAFE_ON, 0, 0, 0, 0, 0, 1, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_MODE, 0, 0, 16'h0080, 0, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::op_t'(4'd12), 0, 0, 0, 0, 0, 0, 0));
		send_cmd(mk_cmd(sobc_pkg::OP_PUSH, 0, 0, 0, 0, 0, 0, 0));
	endtask

	task automatic test_random_phase(input int n, input int s_pct, input int r_pct);
		sobc_pkg::in_item_t it;
		send_idle_pct = s_pct;
		recv_stall_pct = r_pct;
		for (int k = 0; k < n; k++) begin
			// Clear the safety state often enough that ticks can produce codes.
			if ($urandom_range(5, 0) == 0)
				send_cmd(mk_cmd(sobc_pkg::OP_SAFE_OFF, 0, 0, 0, 0, 0, 0, 0));
			it = rand_cmd();
			send_cmd(it);
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		hold_off_req = 1'b1;
		for (int k = 0; k < 6; k++)
			send_cmd(mk_cmd(sobc_pkg::OP_SAFE_ON, 0, 0, 0, 0, 0, 1, 0));
	endtask

	// Receiver: stalls at random, and once for a long stretch when asked.
	always @(negedge clk) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else if (hold_off_req && !hold_served) begin
			res.ready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == HOLD_OFF_CYCLES - 1)
				hold_served <= 1'b1;
		end else begin
			res.ready <= !(recv_stall_pct > 0 && $urandom_range(99, 0) < recv_stall_pct);
		end
	end

	// Result checker: compares each transfer with the oldest expectation.
	always @(posedge clk) begin
		sobc_pkg::res_item_t got;
		sobc_pkg::res_item_t want;
		if (arst_n && res.valid && res.ready) begin
			got.kind = res.kind;
			got.out_channel = res.out_channel;
			got.frame_us = res.frame_us;
			got.pulse_or_code = res.pulse_or_code;
			got.last = res.last;
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: kind %0d ch %0d period %0d val %0d last %0d",
						got.kind, got.out_channel, got.frame_us, got.pulse_or_code, got.last);
			end else begin
				want = pending_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected k%0d c%0d p%0d v%0d l%0d, got k%0d c%0d p%0d v%0d l%0d",
							want.kind, want.out_channel, want.frame_us, want.pulse_or_code,
							want.last, got.kind, got.out_channel, got.frame_us,
							got.pulse_or_code, got.last);
				end
			end
		end
	end

	// Watchdog: counts cycles in which no transfer happens on either channel.
	always @(posedge clk) begin
		if ((cmd.valid && cmd.ready) || (res.valid && res.ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= IDLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cmd.valid = 1'b0;
		cmd.opcode = '0;
		cmd.channel = '0;
		cmd.pulse_width_us = '0;
		cmd.channel_mask = '0;
		cmd.rate_hz = '0;
		cmd.digital_mode = 1'b0;
		cmd.armed = 1'b0;
		cmd.tick = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_req = 1'b0;
		items_sent = 0;
		for (int i = 0; i < N_CH; i++) begin
			pulse_mem[i] = 16'd1000;
			rate_mem[i] = 16'd50;
		end
		en_bits = '0;
		dirty = '0;
		corked = 1'b0;
		safe = 1'b1;
		dig_bank = 1'b0;
		present = 16'hFFFF;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		write_present(16'h0000);
		test_random_phase(10, 0, 0);
		write_present(16'hA5C3);
		test_random_phase(30, 88, 0);
		write_present(16'hFFFF);
		test_random_phase(30, 0, 88);
		write_present(16'h0F01);
		test_random_phase(30, 14, 14);
		write_present(16'hFFFF);
		test_backpressure();
		test_random_phase(10, 0, 0);
		wait_drained();

		$display("Run covered %0d commands and %0d results across five present masks,",
			items_sent, results_seen);
		$display("with idle sender, stalling receiver, both, and a long receiver hold-off.");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
